@@ sv/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared codes and constants of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

   // request codes on the input channel
   typedef enum logic {
      REQ_START   = 1'b0,
      REQ_ADVANCE = 1'b1
   } req_code_type;

   // depth of the command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

endpackage

@@ sv/bls_if.sv @@
// ----------------------------------------------------------------------------
// bls_if
// Valid/ready channels of the line stepper: request and pixel response.
// ----------------------------------------------------------------------------

// request channel: one word starts a line or asks for the next pixel
interface bls_req_if #(
   parameter int unsigned COORD_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;

   modport source (output valid, output req_type, output x_start, output y_start,
                   output x_end, output y_end, input ready);
   modport sink   (input valid, input req_type, input x_start, input y_start,
                   input x_end, input y_end, output ready);
endinterface

// response channel: one pixel per word
interface bls_rsp_if #(
   parameter int unsigned COORD_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_pixel;

   modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                   output ready);
endinterface

@@ sv/bls_front.sv @@
// ----------------------------------------------------------------------------
// bls_front
// Takes request words, works out deltas, directions, major axis and the
// decision constants of a new line, and pushes a command into the queue.
// ----------------------------------------------------------------------------
module bls_front #(
   parameter int unsigned COORD_BITS = 10
) (
   bls_req_if.sink                  req_ch,
   input  logic                     queue_full,
   output logic                     push,
   output logic [6*COORD_BITS+9:0]  push_cmd
);

   localparam int unsigned ERR_BITS = COORD_BITS + 2;

   typedef struct packed {
      logic                       is_start;
      logic [COORD_BITS-1:0]      x0;
      logic [COORD_BITS-1:0]      y0;
      logic                       dir_x_neg;
      logic                       dir_y_neg;
      logic                       major_is_x;
      logic [COORD_BITS-1:0]      steps;
      logic signed [ERR_BITS-1:0] err0;
      logic signed [ERR_BITS-1:0] inc_straight;
      logic signed [ERR_BITS-1:0] inc_diag;
   } cmd_type;

   cmd_type               cmd;
   logic                  dxn;
   logic                  dyn;
   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic                  mx;
   logic [COORD_BITS-1:0] d_major;
   logic [COORD_BITS-1:0] d_minor;
   logic [COORD_BITS:0]   d_diff;

   // absolute deltas and octant
   always_comb begin
      dxn     = req_ch.x_end < req_ch.x_start;
      dyn     = req_ch.y_end < req_ch.y_start;
      dx      = dxn ? (req_ch.x_start - req_ch.x_end) : (req_ch.x_end - req_ch.x_start);
      dy      = dyn ? (req_ch.y_start - req_ch.y_end) : (req_ch.y_end - req_ch.y_start);
      mx      = dx > dy;           // ties go to y
      d_major = mx ? dx : dy;
      d_minor = mx ? dy : dx;
      d_diff  = {1'b0, d_minor} - {1'b0, d_major};   // never positive
   end

   // command word for the back end
   always_comb begin
      cmd = '0;
      if (req_ch.req_type == bls_pkg::REQ_START) begin
         cmd.is_start     = 1'b1;
         cmd.x0           = req_ch.x_start;
         cmd.y0           = req_ch.y_start;
         cmd.dir_x_neg    = dxn;
         cmd.dir_y_neg    = dyn;
         cmd.major_is_x   = mx;
         cmd.steps        = d_major;
         cmd.err0         = {1'b0, d_minor, 1'b0} - {2'b00, d_major};
         cmd.inc_straight = {1'b0, d_minor, 1'b0};
         cmd.inc_diag     = {d_diff, 1'b0};
      end
   end

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;
   assign push_cmd     = cmd;

endmodule

@@ sv/bls_queue.sv @@
// ----------------------------------------------------------------------------
// bls_queue
// Short first-in first-out queue of command words between front and back.
// ----------------------------------------------------------------------------
module bls_queue #(
   parameter int unsigned WIDTH = 70
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   localparam int unsigned DEPTH    = bls_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full  = count_ff == CNT_BITS'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = store[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/bls_back.sv @@
// ----------------------------------------------------------------------------
// bls_back
// Holds the active line and steps it one pixel per command; the current
// position registers double as the response word.
// ----------------------------------------------------------------------------
module bls_back #(
   parameter int unsigned COORD_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  logic [6*COORD_BITS+9:0]  head_cmd,
   output logic                     pop,
   bls_rsp_if.source                rsp_ch
);

   localparam int unsigned ERR_BITS = COORD_BITS + 2;

   typedef struct packed {
      logic                       is_start;
      logic [COORD_BITS-1:0]      x0;
      logic [COORD_BITS-1:0]      y0;
      logic                       dir_x_neg;
      logic                       dir_y_neg;
      logic                       major_is_x;
      logic [COORD_BITS-1:0]      steps;
      logic signed [ERR_BITS-1:0] err0;
      logic signed [ERR_BITS-1:0] inc_straight;
      logic signed [ERR_BITS-1:0] inc_diag;
   } cmd_type;

   cmd_type                    cmd;
   logic                       out_free;
   logic                       minor_step;
   logic                       move_x;
   logic                       move_y;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       active_ff, active_in;
   logic [COORD_BITS-1:0]      cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]      cur_y_ff, cur_y_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic signed [ERR_BITS-1:0] inc_straight_ff, inc_straight_in;
   logic signed [ERR_BITS-1:0] inc_diag_ff, inc_diag_in;
   logic [COORD_BITS-1:0]      steps_ff, steps_in;
   logic                       dir_x_neg_ff, dir_x_neg_in;
   logic                       dir_y_neg_ff, dir_y_neg_in;
   logic                       major_is_x_ff, major_is_x_in;

   assign cmd      = head_cmd;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop      = !queue_empty && out_free;

   // one Bresenham step: major axis always, minor axis when err >= 0
   always_comb begin
      minor_step = !err_ff[ERR_BITS-1];
      move_x     = major_is_x_ff || minor_step;
      move_y     = !major_is_x_ff || minor_step;
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      active_in       = active_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      err_in          = err_ff;
      inc_straight_in = inc_straight_ff;
      inc_diag_in     = inc_diag_ff;
      steps_in        = steps_ff;
      dir_x_neg_in    = dir_x_neg_ff;
      dir_y_neg_in    = dir_y_neg_ff;
      major_is_x_in   = major_is_x_ff;
      if (pop) begin
         if (cmd.is_start) begin
            // new line: drop any line in progress, show the first endpoint
            rsp_valid_in    = 1'b1;
            active_in       = cmd.steps != '0;
            cur_x_in        = cmd.x0;
            cur_y_in        = cmd.y0;
            err_in          = cmd.err0;
            inc_straight_in = cmd.inc_straight;
            inc_diag_in     = cmd.inc_diag;
            steps_in        = cmd.steps;
            dir_x_neg_in    = cmd.dir_x_neg;
            dir_y_neg_in    = cmd.dir_y_neg;
            major_is_x_in   = cmd.major_is_x;
         end else if (active_ff) begin
            rsp_valid_in = 1'b1;
            if (move_x) begin
               cur_x_in = dir_x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (move_y) begin
               cur_y_in = dir_y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
            err_in    = err_ff + (minor_step ? inc_diag_ff : inc_straight_ff);
            steps_in  = steps_ff - 1'b1;
            active_in = steps_ff != COORD_BITS'(1);
         end else begin
            // advance with no line: swallowed
            rsp_valid_in = 1'b0;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   // line state
   always_ff @(posedge clock) begin
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      err_ff          <= err_in;
      inc_straight_ff <= inc_straight_in;
      inc_diag_ff     <= inc_diag_in;
      steps_ff        <= steps_in;
      dir_x_neg_ff    <= dir_x_neg_in;
      dir_y_neg_ff    <= dir_y_neg_in;
      major_is_x_ff   <= major_is_x_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_x    = cur_x_ff;
   assign rsp_ch.pixel_y    = cur_y_ff;
   assign rsp_ch.last_pixel = !active_ff;

endmodule

@@ sv/bresenham_line_stepper_unit.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Integer Bresenham line rasteriser for all octants: a start word loads two
// endpoints and yields the first pixel, each advance word the next one.
// ----------------------------------------------------------------------------
//  channel   dir  word                                        handshake
//  req_ch    in   req_type, x_start, y_start, x_end, y_end    valid/ready
//  rsp_ch    out  pixel_x, pixel_y, last_pixel                valid/ready
//
//  One word a cycle sustained while rsp ready holds; a request word that is taken
//  is first written into the two-entry queue, and the back end then moves it
//  into the output register, where its pixel shows.
//  The rate is set by the back end's single error add per pixel.
//  Synchronous reset empties the queue, drops the line and clears rsp valid.
//  A stalled response holds its pixel; the queue then fills and req ready drops.
//  An advance word with no line in progress is taken and gives no pixel.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit #(
   parameter int unsigned COORD_BITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   bls_req_if.sink   req_ch,
   bls_rsp_if.source rsp_ch
);

   localparam int unsigned CMD_BITS = 6 * COORD_BITS + 10;

   logic                push;
   logic [CMD_BITS-1:0] push_cmd;
   logic                queue_full;
   logic                queue_empty;
   logic                pop;
   logic [CMD_BITS-1:0] head_cmd;

   // classify and prepare
   bls_front #(.COORD_BITS(COORD_BITS)) u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decoupling queue
   bls_queue #(.WIDTH(CMD_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head_cmd)
   );

   // step the line
   bls_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

@@ sv/bls_checker.sv @@
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module bls_checker #(
   parameter int unsigned COORD_BITS = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_type,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] pixel_x,
   input logic [COORD_BITS-1:0] pixel_y,
   input logic                  last_pixel
);

   logic seen_start_ff, seen_start_in;

   // a start word has been taken since reset
   assign seen_start_in = seen_start_ff ||
                          (req_valid && req_ready && req_type == bls_pkg::REQ_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_start_ff <= 1'b0;
      end else begin
         seen_start_ff <= seen_start_in;
      end
   end

   // reset leaves no pixel on the output
   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request is ready (queue not full) straight after reset
   a_ready_after_reset : assert property (@(posedge clock) $past(reset) |-> req_ready)
      else $error("request not ready after reset");

   // a stalled pixel holds
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y)
         && $stable(last_pixel))
      else $error("stalled pixel changed");

   // no pixel without a line having been started
   a_needs_start : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_start_ff)
      else $error("pixel without any start word");

endmodule

bind bresenham_line_stepper_unit bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_type   (req_ch.req_type),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .pixel_x    (rsp_ch.pixel_x),
   .pixel_y    (rsp_ch.pixel_y),
   .last_pixel (rsp_ch.last_pixel)
);
